### hdl/clb_pkg.sv
package clb_pkg;

  localparam int MAX_CORES_DEF = 64;
  localparam int COUNT_W       = 32;
  localparam int ID_W          = 32;
  localparam int CFG_W         = 7;
  localparam int CHOSEN_W      = 6;
  localparam int DIV_STEPS     = 32;
  localparam int STEP_W        = 6;

  localparam logic [1:0] ACT_PICK  = 2'd0;
  localparam logic [1:0] ACT_REG   = 2'd1;
  localparam logic [1:0] ACT_UNREG = 2'd2;

  localparam logic [1:0] POL_LEAST = 2'd1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_FETCH
  } clb_state_t;

endpackage

### hdl/clb_ram.sv
module clb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/clb_mod.sv
module clb_mod #(
  parameter int NW = 7,
  parameter int IW = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [clb_pkg::ID_W-1:0] dividend,
  input  logic [NW-1:0]          divisor,
  output logic                   done,
  output logic [IW-1:0]          remainder
);
  import clb_pkg::*;

  logic [ID_W-1:0]   dvd;
  logic [NW-1:0]     rem;
  logic [STEP_W-1:0] steps;
  logic              running;
  logic [NW:0]       shifted;
  logic [NW:0]       diff;
  logic              fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem, dvd[ID_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(DIV_STEPS);
      end else if (running) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (running) begin
      dvd <= dvd << 1;
      rem <= fits ? diff[NW-1:0] : shifted[NW-1:0];
    end
  end

  assign remainder = rem[IW-1:0];

`ifndef SYNTH
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running))
    else $error("remainder done without a running division");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < divisor)
    else $error("remainder not below divisor");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !running)
    else $error("division restarted while running");
`endif

endmodule

### hdl/core_load_balancer_top.sv
// channel   | beat marker      | payload
// ----------+------------------+-------------------------------------------
// item in   | start & !busy    | action, core_id, use_fixed, policy
// result    | done (one cycle) | chosen_core, core_count, in_range
// config    | cfg_we           | cfg_data (num_cores)
//
// register/unregister: S_FETCH updates the count; out of range, done with no update
// fixed or round-robin pick: 32-step serial remainder in S_DIV, then S_FETCH
// least-loaded pick: S_SCAN reads one count a cycle over the clamped core count
// after reset the count memory is swept to zero in S_CLEAR with busy high
// one item at a time; results cannot be stalled and show while busy is already low
module core_load_balancer_top #(
  parameter int MAX_CORES = clb_pkg::MAX_CORES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [clb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [clb_pkg::ID_W-1:0]      core_id,
  input  logic                          use_fixed,
  input  logic [1:0]                    policy,
  output logic                          done,
  output logic [clb_pkg::CHOSEN_W-1:0]  chosen_core,
  output logic [clb_pkg::COUNT_W-1:0]   core_count,
  output logic                          in_range
);
  import clb_pkg::*;

  localparam int IW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int NW = $clog2(MAX_CORES + 1);

  clb_state_t state, state_next;

  logic [CFG_W-1:0]   num_cores;
  logic [COUNT_W-1:0] rr_count;
  logic [IW-1:0]      clr_addr;
  logic [1:0]         action_q;
  logic [IW-1:0]      core_q;
  logic               ok_q;
  logic [IW-1:0]      chosen_q;
  logic [IW-1:0]      cmp_idx;
  logic [IW-1:0]      best;
  logic [COUNT_W-1:0] low;

  logic [NW-1:0]      n_eff;
  logic               accept;
  logic               ok;
  logic               clr_last;
  logic               scan_last;
  logic               better;
  logic [IW-1:0]      best_next;
  logic [COUNT_W-1:0] low_next;
  logic [COUNT_W-1:0] upd_count;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;

  logic               div_start;
  logic [ID_W-1:0]    div_dividend;
  logic               div_done;
  logic [IW-1:0]      div_rem;

  logic               res_load;
  logic [IW-1:0]      res_chosen;
  logic [COUNT_W-1:0] res_count;
  logic               res_ok;

  always_comb begin
    if (num_cores == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_cores) > MAX_CORES) begin
      n_eff = NW'(MAX_CORES);
    end else begin
      n_eff = NW'(num_cores);
    end
  end

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign ok        = core_id < ID_W'(n_eff);
  assign clr_last  = (clr_addr == IW'(MAX_CORES - 1));
  assign scan_last = (NW'(cmp_idx) == n_eff - NW'(1));
  assign better    = ram_rdata < low;
  assign best_next = better ? cmp_idx : best;
  assign low_next  = better ? ram_rdata : low;

  // saturating decrement on unregister, wrapping increment on register
  always_comb begin
    if (action_q == ACT_REG) begin
      upd_count = ram_rdata + COUNT_W'(1);
    end else if (ram_rdata == '0) begin
      upd_count = '0;
    end else begin
      upd_count = ram_rdata - COUNT_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_PICK: begin
              if (!use_fixed && policy == POL_LEAST) begin
                state_next = S_SCAN;
              end else begin
                state_next = S_DIV;
              end
            end
            ACT_REG, ACT_UNREG: begin
              state_next = ok ? S_FETCH : S_IDLE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_FETCH;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory, divider and result controls
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = core_q;
    ram_wdata    = upd_count;
    ram_raddr    = core_id[IW-1:0];
    div_start    = 1'b0;
    div_dividend = core_id;
    res_load     = 1'b0;
    res_chosen   = '0;
    res_count    = '0;
    res_ok       = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_PICK: begin
              if (use_fixed) begin
                div_start = 1'b1;
              end else if (policy == POL_LEAST) begin
                ram_raddr = '0;
              end else begin
                div_start    = 1'b1;
                div_dividend = rr_count;
              end
            end
            ACT_REG, ACT_UNREG: begin
              res_load = !ok;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_DIV: begin
        ram_raddr = div_rem;
      end
      S_SCAN: begin
        ram_raddr = cmp_idx + IW'(1);
        if (scan_last) begin
          res_load   = 1'b1;
          res_chosen = best_next;
          res_count  = low_next;
          res_ok     = ok_q;
        end
      end
      S_FETCH: begin
        res_load = 1'b1;
        res_ok   = ok_q;
        if (action_q == ACT_PICK) begin
          res_chosen = chosen_q;
          res_count  = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          res_count = upd_count;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      num_cores <= CFG_W'(1);
      rr_count  <= '0;
      clr_addr  <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (cfg_we) begin
        num_cores <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IW'(1);
      end
      if (accept && action == ACT_PICK && !use_fixed && policy != POL_LEAST) begin
        rr_count <= rr_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= action;
      core_q   <= core_id[IW-1:0];
      ok_q     <= ok;
      cmp_idx  <= '0;
      best     <= '0;
      low      <= '1;
    end
    if (state == S_DIV && div_done) begin
      chosen_q <= div_rem;
    end
    if (state == S_SCAN) begin
      cmp_idx <= cmp_idx + IW'(1);
      best    <= best_next;
      low     <= low_next;
    end
    if (res_load) begin
      chosen_core <= CHOSEN_W'(res_chosen);
      core_count  <= res_count;
      in_range    <= res_ok;
    end
  end

  clb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_CORES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  clb_mod #(
    .NW (NW),
    .IW (IW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (n_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

`ifndef SYNTH
  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_FETCH))
    else $error("count memory written outside sweep or update");
  a_div_from_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_IDLE)
    else $error("remainder unit started while busy");
  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> !done)
    else $error("result during memory sweep");
  a_div_waits: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("remainder finished outside wait state");
`endif

endmodule

### tb/core_load_balancer_top_test.sv
module core_load_balancer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import clb_pkg::*;

  // codes the package does not name
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [1:0] POL_ROUND   = 2'd0;
  localparam logic [1:0] POL_FIXED   = 2'd2;
  localparam logic [1:0] POL_NONE    = 2'd3;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic [COUNT_W-1:0]  count;
    logic                in_range;
  } dispatch_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_data;
  logic                start;
  logic                busy;
  logic [1:0]          action;
  logic [ID_W-1:0]     core_id;
  logic                use_fixed;
  logic [1:0]          policy;
  logic                done;
  logic [CHOSEN_W-1:0] chosen_core;
  logic [COUNT_W-1:0]  core_count;
  logic                in_range;

  // mirror of the dispatcher state
  logic [COUNT_W-1:0]  session_cnt [MAX_CORES_DEF];
  logic [31:0]         rr_next;
  logic [CFG_W-1:0]    num_cores_cfg;

  dispatch_result_t    pending_results [$];
  int                  mismatch_count = 0;
  int                  idle_pct = 10;

  core_load_balancer_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .core_id     (core_id),
    .use_fixed   (use_fixed),
    .policy      (policy),
    .done        (done),
    .chosen_core (chosen_core),
    .core_count  (core_count),
    .in_range    (in_range)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] eff_cores();
    if (num_cores_cfg == 0) return 32'd1;
    if (num_cores_cfg > MAX_CORES_DEF) return MAX_CORES_DEF;
    return {25'd0, num_cores_cfg};
  endfunction

  task automatic predict_dispatch(input logic [1:0] act, input logic [31:0] id,
                                  input logic fx, input logic [1:0] pol,
                                  output dispatch_result_t r);
    logic [31:0] n;
    logic [31:0] pick_idx;
    logic [31:0] lowest;
    r = '0;
    n = eff_cores();
    r.in_range = (id < n);
    case (act)
      ACT_PICK: begin
        if (fx) begin
          pick_idx = id % n;
        end else if (pol == POL_LEAST) begin
          pick_idx = 0;
          lowest = '1;
          for (int i = 0; i < n; i++) begin
            if (session_cnt[i] < lowest) begin
              lowest = session_cnt[i];
              pick_idx = i;
            end
          end
        end else begin
          pick_idx = rr_next % n;
          rr_next = rr_next + 1;
        end
        r.chosen = pick_idx[CHOSEN_W-1:0];
        r.count = session_cnt[pick_idx];
      end
      ACT_REG: begin
        if (r.in_range) begin
          session_cnt[id] = session_cnt[id] + 1;
          r.count = session_cnt[id];
        end
      end
      ACT_UNREG: begin
        if (r.in_range) begin
          if (session_cnt[id] != 0) session_cnt[id] = session_cnt[id] - 1;
          r.count = session_cnt[id];
        end
      end
      default: begin
        r = '0;
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(input logic [1:0] act, input logic [31:0] id,
                           input logic fx, input logic [1:0] pol);
    dispatch_result_t want;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    action    <= act;
    core_id   <= id;
    use_fixed <= fx;
    policy    <= pol;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_dispatch(act, id, fx, pol, want);
    pending_results.insert(pending_results.size(), want);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_cores(input logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    num_cores_cfg = val;
  endtask

  function automatic logic [31:0] rand_core_id();
    int unsigned sel;
    logic [31:0] n;
    sel = $urandom_range(99);
    n = eff_cores();
    if (sel < 65) return $urandom_range(0, n - 1);
    if (sel < 80) return n + $urandom_range(0, 3);
    if (sel < 92) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 3);
  endfunction

  task automatic test_defaults_after_reset();
    send_item(ACT_PICK, 32'd0, 1'b0, POL_ROUND);
    send_item(ACT_REG, 32'd0, 1'b0, POL_ROUND);
    send_item(ACT_REG, 32'd1, 1'b0, POL_ROUND);
    send_item(ACT_UNREG, 32'd0, 1'b0, POL_ROUND);
    // count already zero, must stay there
    send_item(ACT_UNREG, 32'd0, 1'b0, POL_ROUND);
    send_item(ACT_UNKNOWN, 32'd0, 1'b1, POL_LEAST);
  endtask

  task automatic test_core_count_limits();
    // zero cores behaves as one
    write_cores(7'd0);
    send_item(ACT_PICK, 32'hFFFF_FFFF, 1'b1, POL_FIXED);
    send_item(ACT_REG, 32'd1, 1'b0, POL_ROUND);
    // above the maximum clamps to 64
    write_cores(7'd127);
    send_item(ACT_REG, 32'd63, 1'b0, POL_ROUND);
    send_item(ACT_REG, 32'd64, 1'b0, POL_ROUND);
    send_item(ACT_PICK, 32'hFFFF_FFFF, 1'b1, POL_NONE);
    write_cores(7'd64);
    send_item(ACT_UNREG, 32'd63, 1'b0, POL_LEAST);
  endtask

  task automatic test_pick_policies();
    write_cores(7'd5);
    send_item(ACT_PICK, 32'd0, 1'b0, POL_LEAST);
    send_item(ACT_PICK, 32'd3, 1'b0, POL_NONE);
    // fixed policy without a fixed id falls back to round robin
    send_item(ACT_PICK, 32'd4, 1'b0, POL_FIXED);
    send_item(ACT_PICK, 32'd7, 1'b1, POL_LEAST);
    send_item(ACT_REG, 32'd4, 1'b1, POL_NONE);
    send_item(ACT_PICK, 32'h8000_0000, 1'b1, POL_FIXED);
  endtask

  task automatic test_hidden_counts();
    write_cores(7'd4);
    send_item(ACT_REG, 32'd3, 1'b0, POL_ROUND);
    write_cores(7'd2);
    send_item(ACT_REG, 32'd3, 1'b0, POL_ROUND);
    // count of core 3 kept while hidden
    write_cores(7'd4);
    send_item(ACT_UNREG, 32'd3, 1'b0, POL_ROUND);
  endtask

  task automatic test_random_traffic(input int pct, input int items_per_setting);
    int unsigned sel;
    logic [1:0]  act;
    idle_pct = pct;
    for (int setting = 0; setting < 4; setting++) begin
      case (setting)
        0: write_cores(7'($urandom_range(1, 8)));
        1: write_cores($urandom_range(0, 1) ? 7'd64 : 7'd127);
        2: write_cores($urandom_range(0, 1) ? 7'd1 : 7'd0);
        default: write_cores(7'($urandom_range(0, 127)));
      endcase
      for (int k = 0; k < items_per_setting; k++) begin
        sel = $urandom_range(99);
        if (sel < 38) act = ACT_REG;
        else if (sel < 60) act = ACT_UNREG;
        else if (sel < 95) act = ACT_PICK;
        else act = ACT_UNKNOWN;
        send_item(act, rand_core_id(), $urandom_range(99) < 30, 2'($urandom_range(0, 3)));
      end
    end
  endtask

  always @(posedge clk) begin : check_result
    dispatch_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: chosen_core %0d core_count %0d in_range %0b",
               chosen_core, core_count, in_range);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (chosen_core !== want.chosen) begin
          $error("chosen_core: expected %0d, got %0d", want.chosen, chosen_core);
          mismatch_count++;
        end
        if (core_count !== want.count) begin
          $error("core_count: expected %0d, got %0d", want.count, core_count);
          mismatch_count++;
        end
        if (in_range !== want.in_range) begin
          $error("in_range: expected %0b, got %0b", want.in_range, in_range);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    start     = 1'b0;
    action    = ACT_PICK;
    core_id   = '0;
    use_fixed = 1'b0;
    policy    = POL_ROUND;
    for (int i = 0; i < MAX_CORES_DEF; i++) session_cnt[i] = '0;
    rr_next = '0;
    num_cores_cfg = 7'd1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    // count memory is swept after reset
    @(negedge clk);
    wait_idle();

    test_defaults_after_reset();
    test_core_count_limits();
    test_pick_policies();
    test_hidden_counts();
    test_random_traffic(10, 42);
    test_random_traffic(54, 42);
    test_random_traffic(0, 42);

    wait_idle();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
hdl/clb_pkg.sv
hdl/clb_ram.sv
hdl/clb_mod.sv
hdl/core_load_balancer_top.sv
tb/core_load_balancer_top_test.sv
